/* hdl/drp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drp_pkg
// Shared types for the DER RSA public key parser: phases, result beats and
// the push bundle from the parse core to the result queue.
// ----------------------------------------------------------------------------
package drp_pkg;

	// depth of the result queue between the parse core and the output port
	localparam int RES_DEPTH = 8;

	// DER tag values
	localparam logic [7:0] TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] TAG_INTEGER  = 8'h02;

	// parse phases, one-hot
	typedef enum logic [12:0] {
		PH_SEQ_TAG  = 13'b0000000000001,
		PH_SEQ_LEN  = 13'b0000000000010,
		PH_SEQ_LENX = 13'b0000000000100,
		PH_N_TAG    = 13'b0000000001000,
		PH_N_LEN    = 13'b0000000010000,
		PH_N_LENX   = 13'b0000000100000,
		PH_N_BODY   = 13'b0000001000000,
		PH_E_TAG    = 13'b0000010000000,
		PH_E_LEN    = 13'b0000100000000,
		PH_E_LENX   = 13'b0001000000000,
		PH_E_BODY   = 13'b0010000000000,
		PH_DONE     = 13'b0100000000000,
		PH_FAIL     = 13'b1000000000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_MODULUS  = 2'd0,
		KIND_EXPONENT = 2'd1,
		KIND_STATUS   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INPUT = 2'd1,
		ST_DER_ERROR = 2'd2
	} status_t;

	// one result beat
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		status_t     status;
		logic [15:0] bits;
		logic [31:0] mod_len;
		logic [31:0] exp_len;
		logic        eor;
	} result_t;

	// up to two results per input byte; slot 1 is only used when slot 0 is
	typedef struct packed {
		logic    v0;
		result_t r0;
		logic    v1;
		result_t r1;
	} push_t;

endpackage
`default_nettype wire

/* hdl/drp_parse_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drp_parse_core
// Per-byte DER walker: tag and length checks, sign byte drop, component
// streaming and final status, all resolved combinationally for each byte.
// ----------------------------------------------------------------------------
module drp_parse_core
	import drp_pkg::*;
#(
	parameter int MAX_LENGTH_OCTETS = 4,
	parameter int MIN_KEY_BYTES     = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid,
	input  wire logic [7:0] data,
	input  wire logic       last,
	output push_t           push
);

	// bit length of one byte
	function automatic logic [3:0] bit_length8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) n = 4'(i + 1);
		end
		return n;
	endfunction

	phase_t      phase_q;
	logic [31:0] acc_q;
	logic [2:0]  left_q;
	logic [31:0] seq_q;
	logic [31:0] int_q;
	logic [3:0]  seen_q;
	logic        fcp_q;
	logic        nz_q;
	logic [15:0] bits_q;
	logic [31:0] mcnt_q;
	logic [31:0] ecnt_q;
	logic        err_q;

	phase_t      ph_eff;
	phase_t      ph_n;
	logic [31:0] acc_n;
	logic [2:0]  left_n;
	logic [31:0] seq_n;
	logic [31:0] int_n;
	logic [3:0]  seen_n;
	logic        fcp_n;
	logic        nz_n;
	logic [15:0] bits_n;
	logic [31:0] mcnt_n;
	logic [31:0] ecnt_n;
	logic        err_n;

	logic        len_done;
	logic [31:0] len_val;
	logic        comp_v;
	kind_t       comp_kind;
	status_t     code;
	logic [6:0]  oct_n;
	logic [16:0] bits_sum;
	result_t     comp_r;
	result_t     stat_r;

	// next state for one byte
	always_comb begin
		ph_n      = phase_q;
		acc_n     = acc_q;
		left_n    = left_q;
		seq_n     = seq_q;
		int_n     = int_q;
		seen_n    = (seen_q == 4'd15) ? seen_q : seen_q + 4'd1;
		fcp_n     = fcp_q;
		nz_n      = nz_q;
		bits_n    = bits_q;
		mcnt_n    = mcnt_q;
		ecnt_n    = ecnt_q;
		err_n     = err_q;
		len_done  = 1'b0;
		len_val   = 32'd0;
		comp_v    = 1'b0;
		comp_kind = KIND_MODULUS;
		oct_n     = data[6:0];
		bits_sum  = {1'b0, bits_q} + 17'd8;
		ph_eff    = phase_q;

		// element must fit in what is left of the sequence
		if (phase_q == PH_N_TAG || phase_q == PH_N_LEN || phase_q == PH_N_LENX ||
			phase_q == PH_N_BODY || phase_q == PH_E_TAG || phase_q == PH_E_LEN ||
			phase_q == PH_E_LENX || phase_q == PH_E_BODY || phase_q == PH_DONE) begin
			if (seq_q == 32'd0) begin
				if (phase_q != PH_DONE) begin
					err_n  = 1'b1;
					ph_n   = PH_FAIL;
					ph_eff = PH_FAIL;
				end
			end else begin
				seq_n = seq_q - 32'd1;
			end
		end

		unique case (ph_eff)
			PH_SEQ_TAG: begin
				if (data == TAG_SEQUENCE) ph_n = PH_SEQ_LEN;
				else begin
					err_n = 1'b1;
					ph_n  = PH_FAIL;
				end
			end
			PH_N_TAG: begin
				if (data == TAG_INTEGER) ph_n = PH_N_LEN;
				else begin
					err_n = 1'b1;
					ph_n  = PH_FAIL;
				end
			end
			PH_E_TAG: begin
				if (data == TAG_INTEGER) ph_n = PH_E_LEN;
				else begin
					err_n = 1'b1;
					ph_n  = PH_FAIL;
				end
			end
			PH_SEQ_LEN, PH_N_LEN, PH_E_LEN: begin
				if (!data[7]) begin
					len_done = 1'b1;
					len_val  = {24'd0, data};
				end else if (oct_n == 7'd0 || oct_n > 7'(MAX_LENGTH_OCTETS)) begin
					err_n = 1'b1;
					ph_n  = PH_FAIL;
				end else begin
					acc_n  = 32'd0;
					left_n = oct_n[2:0];
					unique case (ph_eff)
						PH_SEQ_LEN: ph_n = PH_SEQ_LENX;
						PH_N_LEN:   ph_n = PH_N_LENX;
						default:    ph_n = PH_E_LENX;
					endcase
				end
			end
			PH_SEQ_LENX, PH_N_LENX, PH_E_LENX: begin
				acc_n  = {acc_q[23:0], data};
				left_n = left_q - 3'd1;
				if (left_n == 3'd0) begin
					len_done = 1'b1;
					len_val  = acc_n;
				end
			end
			PH_N_BODY, PH_E_BODY: begin
				int_n = int_q - 32'd1;
				fcp_n = 1'b0;
				if (!(fcp_q && data == 8'h00)) begin
					comp_v = 1'b1;
					if (ph_eff == PH_N_BODY) begin
						comp_kind = KIND_MODULUS;
						mcnt_n    = mcnt_q + 32'd1;
						if (nz_q) begin
							bits_n = bits_sum[16] ? 16'hFFFF : bits_sum[15:0];
						end else if (data != 8'h00) begin
							nz_n   = 1'b1;
							bits_n = {12'd0, bit_length8(data)};
						end
					end else begin
						comp_kind = KIND_EXPONENT;
						ecnt_n    = ecnt_q + 32'd1;
					end
				end
				if (int_n == 32'd0) ph_n = (ph_eff == PH_N_BODY) ? PH_E_TAG : PH_DONE;
			end
			PH_DONE, PH_FAIL: begin
			end
			default: begin
			end
		endcase

		// a complete length closes out its element header
		if (len_done) begin
			if (ph_eff == PH_SEQ_LEN || ph_eff == PH_SEQ_LENX) begin
				seq_n = len_val;
				ph_n  = PH_N_TAG;
			end else if (len_val > seq_n) begin
				err_n = 1'b1;
				ph_n  = PH_FAIL;
			end else begin
				int_n = len_val;
				fcp_n = 1'b1;
				if (ph_eff == PH_N_LEN || ph_eff == PH_N_LENX)
					ph_n = (len_val == 32'd0) ? PH_E_TAG : PH_N_BODY;
				else
					ph_n = (len_val == 32'd0) ? PH_DONE : PH_E_BODY;
			end
		end

		// final status on the last byte
		priority if (seen_n < 4'(MIN_KEY_BYTES)) code = ST_BAD_INPUT;
		else if (err_n || ph_n != PH_DONE || seq_n != 32'd0) code = ST_DER_ERROR;
		else code = ST_OK;
	end

	// result beats for this byte
	always_comb begin
		comp_r         = '0;
		comp_r.kind    = comp_kind;
		comp_r.value   = data;
		comp_r.status  = ST_OK;
		comp_r.eor     = !last;
		stat_r         = '0;
		stat_r.kind    = KIND_STATUS;
		stat_r.status  = code;
		stat_r.eor     = 1'b1;
		if (code == ST_OK) begin
			stat_r.bits    = bits_n;
			stat_r.mod_len = mcnt_n;
			stat_r.exp_len = ecnt_n;
		end
		push = '0;
		if (valid) begin
			if (comp_v) begin
				push.v0 = 1'b1;
				push.r0 = comp_r;
				push.v1 = last;
				push.r1 = stat_r;
			end else begin
				push.v0 = last;
				push.r0 = stat_r;
			end
		end
	end

	// parser state, back to reset after every last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			acc_q   <= '0;
			left_q  <= '0;
			seq_q   <= '0;
			int_q   <= '0;
			seen_q  <= '0;
			fcp_q   <= 1'b0;
			nz_q    <= 1'b0;
			bits_q  <= '0;
			mcnt_q  <= '0;
			ecnt_q  <= '0;
			err_q   <= 1'b0;
		end else if (valid) begin
			if (last) begin
				phase_q <= PH_SEQ_TAG;
				acc_q   <= '0;
				left_q  <= '0;
				seq_q   <= '0;
				int_q   <= '0;
				seen_q  <= '0;
				fcp_q   <= 1'b0;
				nz_q    <= 1'b0;
				bits_q  <= '0;
				mcnt_q  <= '0;
				ecnt_q  <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= ph_n;
				acc_q   <= acc_n;
				left_q  <= left_n;
				seq_q   <= seq_n;
				int_q   <= int_n;
				seen_q  <= seen_n;
				fcp_q   <= fcp_n;
				nz_q    <= nz_n;
				bits_q  <= bits_n;
				mcnt_q  <= mcnt_n;
				ecnt_q  <= ecnt_n;
				err_q   <= err_n;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/drp_result_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drp_result_fifo
// Result queue: takes up to two beats a cycle from the parse core and
// hands them out one beat a cycle while pop is high.
// ----------------------------------------------------------------------------
module drp_result_fifo
	import drp_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire push_t                  push,
	input  wire logic                   pop,
	output result_t                     head,
	output logic                        not_empty,
	output logic [$clog2(DEPTH+1)-1:0]  level
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [AW-1:0]   wr_next1;
	logic [LW-1:0]   level_q;
	logic [LW-1:0]   n_push;
	logic            do_pop;

	assign wr_next1  = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
	assign n_push    = LW'(push.v0) + LW'(push.v1);
	assign do_pop    = pop && (level_q != '0);
	assign head      = mem_q[rd_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push.v0) mem_q[wr_q] <= push.r0;
		if (push.v1) mem_q[wr_next1] <= push.r1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push.v1) wr_q <= (wr_next1 == AW'(DEPTH - 1)) ? '0 : wr_next1 + AW'(1);
			else if (push.v0) wr_q <= wr_next1;
			if (do_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			level_q <= level_q + n_push - LW'(do_pop);
		end
	end

endmodule
`default_nettype wire

/* hdl/der_rsa_public_key_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// der_rsa_public_key_parser: a byte beat passes the input register and the parse
// core into the result queue; throughput 1 byte per cycle while in_ready is high
// a last byte that yields two results drains them one at a time at the queue port
// async reset clears parser state and result queue at once, no clearing pass
// ----------------------------------------------------------------------------
module der_rsa_public_key_parser
	import drp_pkg::*;
#(
	parameter int MAX_LENGTH_OCTETS = 4,
	parameter int MIN_KEY_BYTES     = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       item_kind,
	output logic [7:0]       value_byte,
	output logic [1:0]       status_code,
	output logic [15:0]      modulus_bit_count,
	output logic [31:0]      modulus_byte_count,
	output logic [31:0]      exponent_byte_count,
	output logic             end_of_run
);

	localparam int LW = $clog2(RES_DEPTH + 1);

	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          last_s1;
	push_t         push;
	result_t       head;
	logic [LW-1:0] level;
	logic [LW:0]   need;

	// room for two more beats beyond what is queued and in flight
	assign need     = {1'b0, level} + (valid_s1 ? (LW+1)'(2) : '0);
	assign in_ready = (need <= (LW+1)'(RES_DEPTH - 2));

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	drp_parse_core #(
		.MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS),
		.MIN_KEY_BYTES     (MIN_KEY_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.data   (data_s1),
		.last   (last_s1),
		.push   (push)
	);

	drp_result_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_ready),
		.head      (head),
		.not_empty (out_valid),
		.level     (level)
	);

	// output beat fields
	assign item_kind           = head.kind;
	assign value_byte          = head.value;
	assign status_code         = head.status;
	assign modulus_bit_count   = head.bits;
	assign modulus_byte_count  = head.mod_len;
	assign exponent_byte_count = head.exp_len;
	assign end_of_run          = head.eor;

	// checks
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LW'(RES_DEPTH))
		else $error("result queue over capacity");

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (push.v0 && push.r1.kind == KIND_STATUS && push.r1.eor))
		else $error("second result slot used out of order");

	a_single_eor: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && !push.v1) |-> push.r0.eor)
		else $error("end of run mark wrong on single result");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && push.r0.kind == KIND_STATUS) |-> last_s1)
		else $error("status beat on a byte that is not last");

endmodule
`default_nettype wire
